FILE: src/frk_pkg.sv
// ----------------------------------------------------------------------------
// frk_pkg - shared types and constants for the top-k free region statistics
// Field widths, limits and the control bundle that drives the cell row.
// ----------------------------------------------------------------------------
package frk_pkg;

  // field widths
  localparam int SIZE_W  = 48;
  localparam int SUM_W   = 52;
  localparam int COUNT_W = 16;

  // default number of kept sizes
  localparam int KEEP_COUNT_DEF = 10;

  // saturation limits
  localparam logic [SIZE_W-1:0]  SIZE_MAX  = {SIZE_W{1'b1}};
  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // control broadcast to every cell of the row
  typedef struct packed {
    logic              take;   // an accepted item carries a region
    logic              clear;  // walk ends, return to reset values
    logic [SIZE_W-1:0] size;   // region size offered to the row
  } frk_ctl_t;

endpackage

FILE: src/frk_if.sv
// ----------------------------------------------------------------------------
// frk_in_if / frk_out_if - valid/ready channels of the statistics unit
// Input channel carries one region item, output channel one walk summary.
// ----------------------------------------------------------------------------
interface frk_in_if;
  import frk_pkg::*;

  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] region_bytes;
  logic              has_region;
  logic              is_last;

  modport source (output valid, output region_bytes, output has_region,
                  output is_last, input ready);
  modport sink   (input valid, input region_bytes, input has_region,
                  input is_last, output ready);
endinterface

interface frk_out_if;
  import frk_pkg::*;

  logic               valid;
  logic               ready;
  logic [SUM_W-1:0]   top_sum;
  logic [SIZE_W-1:0]  total_free;
  logic [SIZE_W-1:0]  largest_free;
  logic [COUNT_W-1:0] region_count;

  modport source (output valid, output top_sum, output total_free,
                  output largest_free, output region_count, input ready);
  modport sink   (input valid, input top_sum, input total_free,
                  input largest_free, input region_count, output ready);
endinterface

FILE: src/frk_cell.sv
// ----------------------------------------------------------------------------
// frk_cell - one slot of the sorted row of kept region sizes
// Holds one size; takes the new size or its upper neighbour's value when the
// new size is larger than its own, so the row stays sorted largest first.
// ----------------------------------------------------------------------------
module frk_cell
  import frk_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  frk_ctl_t          ctl,
  input  logic [SIZE_W-1:0] up_val,
  input  logic              up_gt,
  output logic [SIZE_W-1:0] val,
  output logic              gt
);

  logic [SIZE_W-1:0] val_r;
  logic [SIZE_W-1:0] val_nxt;

  // new size beats the value held here
  assign gt  = ctl.size > val_r;
  assign val = val_r;

  // clear, or insert or shift down from the neighbour
  always_comb begin
    val_nxt = val_r;
    if (ctl.clear) begin
      val_nxt = '0;
    end else if (ctl.take && gt) begin
      val_nxt = up_gt ? up_val : ctl.size;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= val_nxt;
    end
  end

endmodule

FILE: src/free_region_top_k_stats_unit.sv
// ----------------------------------------------------------------------------
// free_region_top_k_stats_unit - top-k free region statistics over one walk
//
// Feed one free-list walk as items on in_ch: region_bytes with has_region set,
// the final item with is_last set (has_region may be clear on it so that an
// empty walk can be reported). Items without is_last give no result.
// On the last item one summary leaves on out_ch: sum of the KEEP_COUNT
// largest sizes (saturating at 2^52-1), total free space (saturating at
// 2^48-1), largest region and region count (saturating at 65535); the
// statistics then return to zero for the next walk.
// Throughput is one item per cycle while in_ch.ready is high: a row of
// KEEP_COUNT cells compares the new size against every kept size in parallel
// and shifts. The summary is in the output register in the cycle after the
// last item is taken. The input stays ready while a summary waits, unless
// another last item arrives before out_ch takes the pending one; then
// in_ch.ready drops until out_ch.ready is seen. Synchronous reset clears all
// statistics and the output valid flag, not the summary fields.
// ----------------------------------------------------------------------------
module free_region_top_k_stats_unit
  import frk_pkg::*;
#(
  parameter int KEEP_COUNT = KEEP_COUNT_DEF
)(
  input  logic             clk,
  input  logic             rst_n,
  frk_in_if.sink           in_ch,
  frk_out_if.source        out_ch
);

  localparam int ACC_W = SIZE_W + $clog2(KEEP_COUNT);
  localparam int CMP_W = (ACC_W > SUM_W) ? ACC_W : SUM_W;

  frk_ctl_t          ctl;
  logic [SIZE_W-1:0] cell_val [KEEP_COUNT];
  logic              cell_gt  [KEEP_COUNT];
  logic              in_acc;
  logic              out_hold;

  logic [ACC_W-1:0]   acc_r,   acc_nxt;
  logic [SIZE_W-1:0]  total_r, total_nxt;
  logic [SIZE_W-1:0]  max_r,   max_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [SIZE_W:0]    total_sum;
  logic [SIZE_W-1:0]  gain;
  logic [CMP_W-1:0]   acc_ext;
  logic [SUM_W-1:0]   top_sat;

  logic               out_valid_r;
  logic [SUM_W-1:0]   out_top_r;
  logic [SIZE_W-1:0]  out_total_r;
  logic [SIZE_W-1:0]  out_max_r;
  logic [COUNT_W-1:0] out_count_r;

  // handshake: hold off a last item only while a summary is pending and not taken
  assign out_hold    = out_valid_r && !out_ch.ready;
  assign in_ch.ready = !(out_hold && in_ch.is_last);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // control for the cell row
  assign ctl.take  = in_acc && in_ch.has_region;
  assign ctl.clear = in_acc && in_ch.is_last;
  assign ctl.size  = in_ch.region_bytes;

  // row of sorted cells, largest first
  for (genvar i = 0; i < KEEP_COUNT; i++) begin : g_cell
    if (i == 0) begin : g_head
      frk_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .up_val ({SIZE_W{1'b0}}),
        .up_gt  (1'b0),
        .val    (cell_val[i]),
        .gt     (cell_gt[i])
      );
    end else begin : g_body
      frk_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .up_val (cell_val[i-1]),
        .up_gt  (cell_gt[i-1]),
        .val    (cell_val[i]),
        .gt     (cell_gt[i])
      );
    end
  end

  // sum of kept sizes tracked incrementally: new size replaces the smallest
  assign gain = cell_gt[KEEP_COUNT-1] ? (ctl.size - cell_val[KEEP_COUNT-1]) : '0;

  // running statistics including the current item
  assign total_sum = {1'b0, total_r} + {1'b0, ctl.size};

  always_comb begin
    acc_nxt   = acc_r;
    total_nxt = total_r;
    max_nxt   = max_r;
    count_nxt = count_r;
    if (ctl.take) begin
      acc_nxt   = acc_r + ACC_W'(gain);
      total_nxt = total_sum[SIZE_W] ? SIZE_MAX : total_sum[SIZE_W-1:0];
      max_nxt   = (ctl.size > max_r) ? ctl.size : max_r;
      count_nxt = (count_r == COUNT_MAX) ? count_r : count_r + COUNT_W'(1);
    end
  end

  // saturate the kept sum to the output width
  assign acc_ext = CMP_W'(acc_nxt);
  assign top_sat = (acc_ext > CMP_W'(SUM_MAX)) ? SUM_MAX : acc_ext[SUM_W-1:0];

  // statistics registers, cleared at the end of each walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      total_r <= '0;
      max_r   <= '0;
      count_r <= '0;
    end else if (ctl.clear) begin
      acc_r   <= '0;
      total_r <= '0;
      max_r   <= '0;
      count_r <= '0;
    end else begin
      acc_r   <= acc_nxt;
      total_r <= total_nxt;
      max_r   <= max_nxt;
      count_r <= count_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.clear) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      out_top_r   <= top_sat;
      out_total_r <= total_nxt;
      out_max_r   <= max_nxt;
      out_count_r <= count_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.top_sum      = out_top_r;
  assign out_ch.total_free   = out_total_r;
  assign out_ch.largest_free = out_max_r;
  assign out_ch.region_count = out_count_r;

endmodule
